[hdl/cwmf_pkg.sv]
// Shared types and constants of the clipped window median filter.
package cwmf_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

  // Widths of the configuration registers and the port
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 13;
  localparam int RADIUS_BITS = 2;
  localparam int CFG_BITS    = 13;
  // Row counter holds height plus radius
  localparam int ROW_BITS    = 14;
  // Guard width used to saturate the width register
  localparam int WCLAMP_BITS = 14;

  // Input request
  typedef struct packed {
    logic        kind;
    logic [15:0] pixel_value;
  } in_t;

  // Result request
  typedef struct packed {
    logic [15:0] filtered_value;
    logic        end_of_row;
    logic        end_of_slice;
  } out_t;

  // Row and slice marks carried along with a window
  typedef struct packed {
    logic end_of_row;
    logic end_of_slice;
  } meta_t;

endpackage

[hdl/clipped_window_median_filter.sv]
// Top level of the clipped window median filter: counters, line store, window.
// Takes one pixel or pad request per clock whenever the output is not stalled;
// an output stall holds every stage and reaches the input stall in the same
// cycle. A result leaves six register stages after its request
// (input, line store read, window, compare, select, output), counted from
// the request that completes its window. Each row is followed by radius pad
// requests and each slice by radius padded rows; a slice gives width*height
// results. The line store is 2*MAX_RADIUS rows deep and needs no clearing
// after reset. Write configuration only while the block is idle.
module clipped_window_median_filter #(
  parameter int MAX_RADIUS = 2,
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  cwmf_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output cwmf_pkg::out_t                     out_data,
  input  logic                               cfg_write,
  input  logic [1:0]                         cfg_index,
  input  logic [cwmf_pkg::CFG_BITS-1:0]      cfg_data
);

  localparam int WIN   = 2 * MAX_RADIUS + 1;
  localparam int N     = WIN * WIN;
  localparam int LINES = 2 * MAX_RADIUS;
  localparam int PB    = PIXEL_BITS;
  localparam int CW    = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int RW    = cwmf_pkg::ROW_BITS;
  localparam int LW    = LINES * PB;

  // Configuration registers
  logic [cwmf_pkg::WIDTH_BITS-1:0]  image_width;
  logic [cwmf_pkg::HEIGHT_BITS-1:0] image_height;
  logic [cwmf_pkg::RADIUS_BITS-1:0] window_radius;
  logic [cwmf_pkg::WCLAMP_BITS-1:0] w_wide;
  logic [CW-1:0]                    w_eff;
  logic [RW-1:0]                    h_eff;
  logic [cwmf_pkg::RADIUS_BITS-1:0] rad_eff;

  // Position counters
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;

  // Input stage
  logic          v0;
  logic [PB-1:0] s0_val;
  logic [CW-1:0] s0_c;
  logic [RW-1:0] s0_r;

  // Line read stage
  logic          v1;
  logic [PB-1:0] s1_val;
  logic [CW-1:0] s1_c;
  logic [RW-1:0] s1_r;
  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] rd_q;
  logic          byp_q;
  logic [LW-1:0] byp_data_q;
  logic [LW-1:0] line;
  logic [LW-1:0] wr_data;
  logic          rd_en;
  logic          wr_en;
  logic          s1_in;
  logic          s1_res;
  cwmf_pkg::meta_t s1_meta;
  logic [WIN-1:0] row_ok;
  logic [WIN-1:0] col_ok;
  logic [N-1:0]   s1_mask;
  logic [RW-1:0]  r_rel;
  logic [CW-1:0]  c_rel;

  // Window stage
  logic            v2;
  logic [PB-1:0]   win [WIN][WIN];
  logic [N*PB-1:0] samples;
  logic [N-1:0]    mask2;
  cwmf_pkg::meta_t meta2;
  logic            med_stall;

  logic en0;
  logic en1;
  logic en2;

  // Saturate the configuration to what the hardware holds
  always_comb begin
    w_wide = cwmf_pkg::WCLAMP_BITS'(image_width);
    if (w_wide == '0) w_wide = cwmf_pkg::WCLAMP_BITS'(1);
    if (w_wide > cwmf_pkg::WCLAMP_BITS'(MAX_WIDTH)) w_wide = cwmf_pkg::WCLAMP_BITS'(MAX_WIDTH);
    w_eff = CW'(w_wide);
    h_eff = RW'(image_height);
    if (image_height == '0) h_eff = RW'(1);
    rad_eff = window_radius;
    if (32'(window_radius) > MAX_RADIUS) rad_eff = cwmf_pkg::RADIUS_BITS'(MAX_RADIUS);
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= cwmf_pkg::WIDTH_BITS'(1024);
      image_height  <= cwmf_pkg::HEIGHT_BITS'(1024);
      window_radius <= cwmf_pkg::RADIUS_BITS'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        cwmf_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[cwmf_pkg::WIDTH_BITS-1:0];
        cwmf_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[cwmf_pkg::HEIGHT_BITS-1:0];
        cwmf_pkg::REG_WINDOW_RADIUS: window_radius <= cfg_data[cwmf_pkg::RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Advance each stage when the one after it is empty or moving
  assign en2      = !v2 || !med_stall;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign in_stall = !en0;

  // Step the position through the padded slice
  always_comb begin
    col_next = col + CW'(1);
    row_next = row;
    if ((CW+1)'(col_next) >= (CW+1)'(w_eff) + (CW+1)'(rad_eff)) begin
      col_next = '0;
      row_next = row + RW'(1);
      if ((RW+1)'(row_next) >= (RW+1)'(h_eff) + (RW+1)'(rad_eff)) row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      v0  <= 1'b0;
    end else begin
      if (in_valid && en0) begin
        col <= col_next;
        row <= row_next;
      end
      if (en0) v0 <= in_valid;
    end
    if (en0) begin
      s0_val <= in_data.pixel_value[PB-1:0];
      s0_c   <= col;
      s0_r   <= row;
    end
  end

  // Read the line store; forward a write to the same column
  assign rd_en   = v0 && en1;
  assign s1_in   = s1_c < w_eff;
  assign wr_en   = v1 && en2 && s1_in;
  assign line    = byp_q ? byp_data_q : rd_q;
  assign wr_data = {line[LW-PB-1:0], s1_val};

  always_ff @(posedge clk) begin
    if (wr_en) line_mem[s1_c[AW-1:0]] <= wr_data;
    if (rd_en) begin
      rd_q       <= line_mem[s0_c[AW-1:0]];
      byp_q      <= wr_en && (s1_c == s0_c);
      byp_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= v0;
    end
    if (en1) begin
      s1_val <= s0_val;
      s1_c   <= s0_c;
      s1_r   <= s0_r;
    end
  end

  // Decide which window rows and columns lie inside the slice
  always_comb begin
    for (int a = 0; a < WIN; a++) begin
      row_ok[a] = (a <= 2 * int'(rad_eff)) && (RW'(a) <= s1_r) &&
                  ((s1_r - RW'(a)) < h_eff);
      col_ok[a] = (a <= 2 * int'(rad_eff)) && (CW'(a) <= s1_c) &&
                  ((s1_c - CW'(a)) < w_eff);
    end
    for (int a = 0; a < WIN; a++) begin
      for (int b = 0; b < WIN; b++) begin
        s1_mask[a*WIN+b] = row_ok[a] && col_ok[b];
      end
    end
    r_rel  = s1_r - RW'(rad_eff);
    c_rel  = s1_c - CW'(rad_eff);
    s1_res = (s1_r >= RW'(rad_eff)) && (s1_c >= CW'(rad_eff)) &&
             (r_rel < h_eff) && (c_rel < w_eff);
    s1_meta.end_of_row   = (c_rel == w_eff - CW'(1));
    s1_meta.end_of_slice = (c_rel == w_eff - CW'(1)) && (r_rel == h_eff - RW'(1));
  end

  // Shift the window by one column; drop items that give no result
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      for (int a = 0; a < WIN; a++) begin
        for (int b = 0; b < WIN; b++) begin
          win[a][b] <= '0;
        end
      end
    end else begin
      if (en2) v2 <= v1 && s1_res;
      if (v1 && en2) begin
        for (int a = 0; a < WIN; a++) begin
          for (int b = WIN - 1; b > 0; b--) begin
            win[a][b] <= win[a][b-1];
          end
        end
        win[0][0] <= s1_in ? s1_val : '0;
        for (int k = 1; k < WIN; k++) begin
          win[k][0] <= s1_in ? line[(k-1)*PB +: PB] : '0;
        end
      end
    end
    if (en2) begin
      mask2 <= s1_mask;
      meta2 <= s1_meta;
    end
  end

  always_comb begin
    for (int a = 0; a < WIN; a++) begin
      for (int b = 0; b < WIN; b++) begin
        samples[(a*WIN+b)*PB +: PB] = win[a][b];
      end
    end
  end

  cwmf_median #(
    .N  (N),
    .PB (PB)
  ) u_median (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_stall  (med_stall),
    .samples   (samples),
    .mask      (mask2),
    .meta      (meta2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A held line stage is never overwritten
  a_hold_s1: assert property (@(posedge clk) disable iff (rst) v1 && !en2 |-> !en1)
    else $error("line stage overwritten while held");

  // Line store writes stay inside the row
  a_wr_range: assert property (@(posedge clk) disable iff (rst) wr_en |-> s1_c < w_eff)
    else $error("line store write beyond row");

  // End of slice comes only with end of row
  a_eos_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.end_of_slice |-> out_data.end_of_row)
    else $error("end of slice without end of row");

  // Counters leave reset at the slice origin
  a_rst_pos: assert property (@(posedge clk) $fell(rst) |-> col == '0 && row == '0)
    else $error("position not cleared by reset");

endmodule

[hdl/cwmf_median.sv]
// Pipelined median of a masked window: rank by pairwise compare, select, average.
module cwmf_median #(
  parameter int N  = 25,
  parameter int PB = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [N*PB-1:0]     samples,
  input  logic [N-1:0]        mask,
  input  cwmf_pkg::meta_t     meta,
  output logic                out_valid,
  input  logic                out_stall,
  output cwmf_pkg::out_t      out_data
);

  localparam int IW = $clog2(N + 1);

  // Compare stage
  logic            va;
  logic [N-1:0]    lt_a [N];
  logic [N-1:0]    lt_next [N];
  logic [N*PB-1:0] x_a;
  logic [N-1:0]    mask_a;
  logic [IW-1:0]   n_a;
  cwmf_pkg::meta_t meta_a;

  // Select stage
  logic            vb;
  logic [PB-1:0]   lo_b;
  logic [PB-1:0]   hi_b;
  logic [PB-1:0]   lo_next;
  logic [PB-1:0]   hi_next;
  logic [IW-1:0]   lo_rank;
  logic [IW-1:0]   hi_rank;
  logic [IW-1:0]   rank [N];
  cwmf_pkg::meta_t meta_b;

  logic [PB:0]     sum;
  logic            en_o;
  logic            en_b;
  logic            en_a;

  // Advance each stage when the one after it is empty or moving
  assign en_o     = !out_valid || !out_stall;
  assign en_b     = !vb || en_o;
  assign en_a     = !va || en_b;
  assign in_stall = !en_a;

  // Order every sample against every other; ties break on position
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        lt_next[i][j] = mask[j] &&
          ((samples[j*PB +: PB] < samples[i*PB +: PB]) ||
           ((samples[j*PB +: PB] == samples[i*PB +: PB]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en_a) begin
      va <= in_valid;
    end
    if (en_a) begin
      lt_a   <= lt_next;
      x_a    <= samples;
      mask_a <= mask;
      n_a    <= IW'($countones(mask));
      meta_a <= meta;
    end
  end

  // Pick the two middle samples by rank
  assign lo_rank = (n_a - IW'(1)) >> 1;
  assign hi_rank = n_a >> 1;

  always_comb begin
    lo_next = '0;
    hi_next = '0;
    for (int i = 0; i < N; i++) begin
      rank[i] = IW'($countones(lt_a[i]));
      if (mask_a[i] && rank[i] == lo_rank) lo_next = lo_next | x_a[i*PB +: PB];
      if (mask_a[i] && rank[i] == hi_rank) hi_next = hi_next | x_a[i*PB +: PB];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en_b) begin
      vb <= va;
    end
    if (en_b) begin
      lo_b   <= lo_next;
      hi_b   <= hi_next;
      meta_b <= meta_a;
    end
  end

  // Floor of the mean of the middle pair
  assign sum = {1'b0, lo_b} + {1'b0, hi_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_o) begin
      out_valid <= vb;
    end
    if (en_o) begin
      out_data.filtered_value <= 16'(sum[PB:1]);
      out_data.end_of_row     <= meta_b.end_of_row;
      out_data.end_of_slice   <= meta_b.end_of_slice;
    end
  end

endmodule

[dv/clipped_window_median_filter_test.sv]
// Testbench for the clipped window median filter: predictor, driver, monitor.
`timescale 1ns / 1ps

module clipped_window_median_filter_test;

  localparam int MAX_RAD = 2;
  localparam int MAX_W   = 1024;
  localparam int WIN     = 2 * MAX_RAD + 1;
  localparam int LINES   = 2 * MAX_RAD;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  cwmf_pkg::in_t                 in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  cwmf_pkg::out_t                out_data;
  logic                          cfg_write = 1'b0;
  logic [1:0]                    cfg_index = cwmf_pkg::REG_IMAGE_WIDTH;
  logic [cwmf_pkg::CFG_BITS-1:0] cfg_data = '0;

  clipped_window_median_filter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Pending requests, expected results and scoreboard counters
  cwmf_pkg::in_t  pending_px[$];
  cwmf_pkg::out_t median_q[$];
  int unsigned    mismatches = 0;
  int unsigned    cycle_cnt = 0;

  // Predictor state: shadow registers, line store, window, raster position
  logic [cwmf_pkg::WIDTH_BITS-1:0]  img_w = 11'd1024;
  logic [cwmf_pkg::HEIGHT_BITS-1:0] img_h = 13'd1024;
  logic [cwmf_pkg::RADIUS_BITS-1:0] win_rad = 2'd1;
  logic [15:0]                      line_mem[0:MAX_W-1][0:LINES-1];
  logic [15:0]                      win_px[0:WIN-1][0:WIN-1];
  int unsigned                      col_pos = 0;
  int unsigned                      row_pos = 0;

  initial begin
    for (int i = 0; i < MAX_W; i++)
      for (int k = 0; k < LINES; k++) line_mem[i][k] = '0;
    for (int a = 0; a < WIN; a++)
      for (int b = 0; b < WIN; b++) win_px[a][b] = '0;
  end

  // Advance the window by one request and queue the median it yields
  task automatic predict_median(input cwmf_pkg::in_t px);
    int unsigned w, h, rad, c, r, n, j, t, med;
    int unsigned vals[WIN*WIN];
    cwmf_pkg::out_t res;
    w = (img_w == 0) ? 1 : ((img_w > MAX_W) ? MAX_W : img_w);
    h = (img_h == 0) ? 1 : img_h;
    rad = (win_rad > MAX_RAD) ? MAX_RAD : win_rad;
    c = col_pos;
    r = row_pos;
    for (int a = 0; a < WIN; a++)
      for (int b = WIN - 1; b > 0; b--) win_px[a][b] = win_px[a][b-1];
    if (c < w) begin
      win_px[0][0] = px.pixel_value;
      for (int k = 1; k < WIN; k++) win_px[k][0] = line_mem[c][k-1];
      for (int k = LINES - 1; k > 0; k--) line_mem[c][k] = line_mem[c][k-1];
      line_mem[c][0] = px.pixel_value;
    end else begin
      for (int k = 0; k < WIN; k++) win_px[k][0] = '0;
    end
    if (r >= rad && c >= rad && r - rad < h && c - rad < w) begin
      n = 0;
      for (int a = 0; a <= 2 * rad; a++) begin
        if (a > r || r - a >= h) continue;
        for (int b = 0; b <= 2 * rad; b++) begin
          if (b > c || c - b >= w) continue;
          vals[n] = win_px[a][b];
          n++;
        end
      end
      // Sort the valid samples, then take the middle or the mean of two
      for (int i = 1; i < n; i++) begin
        t = vals[i];
        j = i;
        while (j > 0 && vals[j-1] > t) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = t;
      end
      med = n[0] ? vals[(n-1)/2] : (vals[n/2-1] + vals[n/2]) >> 1;
      res.filtered_value = med[15:0];
      res.end_of_row = (c - rad == w - 1);
      res.end_of_slice = (c - rad == w - 1) && (r - rad == h - 1);
      median_q.push_back(res);
    end
    c++;
    if (c >= w + rad) begin
      c = 0;
      r++;
      if (r >= h + rad) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // Idle at random with a 21 percent chance, except in a quiet stretch at the start of each period
  function automatic bit take_break();
    return ((cycle_cnt % 5000) >= 1200) && ($urandom_range(0, 99) < 21);
  endfunction

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Driver: hold a stalled request, advance on accept
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_median(pending_px.pop_front());
      if (!in_valid || !in_stall) begin
        if (pending_px.size() > 0 && !take_break()) begin
          in_valid <= 1'b1;
          in_data <= pending_px[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (median_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %h at cycle %0d", out_data, cycle_cnt);
        end else begin
          cwmf_pkg::out_t exp_res;
          exp_res = median_q.pop_front();
          if (exp_res.filtered_value != out_data.filtered_value ||
              exp_res.end_of_row != out_data.end_of_row ||
              exp_res.end_of_slice != out_data.end_of_slice) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %h eor %b eos %b, got %h %b %b",
                       exp_res.filtered_value, exp_res.end_of_row,
                       exp_res.end_of_slice, out_data.filtered_value,
                       out_data.end_of_row, out_data.end_of_slice);
          end
        end
      end
      out_stall <= take_break();
    end
  end

  // Drop config into the shadow copy and onto the port
  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[cwmf_pkg::CFG_BITS-1:0];
    case (idx)
      cwmf_pkg::REG_IMAGE_WIDTH:   img_w = val[cwmf_pkg::WIDTH_BITS-1:0];
      cwmf_pkg::REG_IMAGE_HEIGHT:  img_h = val[cwmf_pkg::HEIGHT_BITS-1:0];
      cwmf_pkg::REG_WINDOW_RADIUS: win_rad = val[cwmf_pkg::RADIUS_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait until every request is in and every result is out
  task automatic drain();
    while (pending_px.size() > 0 || in_valid || median_q.size() > 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Configure, then queue one padded slice; extremes come from the caller
  task automatic run_slice(input int unsigned w, input int unsigned h,
                           input int unsigned rad, input bit fixed_vals,
                           input logic [15:0] fixed_px);
    int unsigned ew, eh, er;
    cwmf_pkg::in_t px;
    drain();
    write_reg(cwmf_pkg::REG_IMAGE_WIDTH, w);
    write_reg(cwmf_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(cwmf_pkg::REG_WINDOW_RADIUS, rad);
    ew = (img_w == 0) ? 1 : ((img_w > MAX_W) ? MAX_W : img_w);
    eh = (img_h == 0) ? 1 : img_h;
    er = (win_rad > MAX_RAD) ? MAX_RAD : win_rad;
    for (int r = 0; r < eh + er; r++)
      for (int c = 0; c < ew + er; c++) begin
        px.pixel_value = fixed_vals ? fixed_px : pick_value();
        // Pad positions carry kind 1; a few real pixels get a stray kind
        px.kind = (r >= eh || c >= ew) ? 1'b1 : ($urandom_range(0, 19) == 0);
        if (fixed_vals && (r + c) % 2 == 1) px.pixel_value = ~fixed_px;
        pending_px.push_back(px);
      end
  endtask

  initial begin
    int unsigned sent;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // Directed: alternating extremes, zero width and height, radius above max
    run_slice(3, 2, 1, 1'b1, 16'h0000);
    run_slice(0, 0, 3, 1'b1, 16'hFFFF);
    run_slice(2, 1, 0, 1'b1, 16'hFFFF);
    // Random small slices
    sent = 0;
    while (sent < 300) begin
      int unsigned w, h, rad, er;
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 7);
      rad = $urandom_range(0, 3);
      er = (rad > MAX_RAD) ? MAX_RAD : rad;
      run_slice(w, h, rad, 1'b0, '0);
      sent += (w + er) * (h + er);
    end
    // Saturated width in a single row, then one more small slice
    run_slice(2047, 1, 0, 1'b0, '0);
    run_slice(5, 3, 2, 1'b0, '0);
    drain();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
hdl/cwmf_pkg.sv
hdl/cwmf_median.sv
hdl/clipped_window_median_filter.sv
dv/clipped_window_median_filter_test.sv
